### src/bct_pkg.sv
// Shared types and constants for the Bloom change tracker.
`timescale 1ns / 1ps

package bct_pkg;

    // Hash word width and filter geometry.
    localparam int WORD_W       = 32;
    localparam int FILTER_BITS  = 16;
    localparam int FILTER_IDX_W = 4;
    localparam int OWNER_W      = 16;

    // Command codes carried by the command field.
    localparam logic [2:0] CMD_MARK_CHANGED = 3'd0;
    localparam logic [2:0] CMD_MARK_GLOBAL  = 3'd1;
    localparam logic [2:0] CMD_QUERY        = 3'd2;
    localparam logic [2:0] CMD_CLEAR        = 3'd3;
    localparam logic [2:0] CMD_REMARK       = 3'd4;

    // MurmurHash3 x86_32 constants.
    localparam logic [WORD_W-1:0] MM_C1    = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MM_C2    = 32'h1b873593;
    localparam logic [WORD_W-1:0] MM_ADD   = 32'he6546b64;
    localparam logic [WORD_W-1:0] MM_FMIX1 = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] MM_FMIX2 = 32'hc2b2ae35;
    localparam logic [WORD_W-1:0] MM_BODY  = 32'd5;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCR_A,
        ST_SCR_B,
        ST_SCR_C,
        ST_ACC_A,
        ST_ACC_B,
        ST_FIN_A,
        ST_FIN_B,
        ST_FIN_C,
        ST_EMIT
    } state_t;

endpackage

### src/bct_mul.sv
// Shared 32-bit multiplier with a registered low-half product.
`timescale 1ns / 1ps

module bct_mul (
    input  logic                         clk,
    input  logic [bct_pkg::WORD_W-1:0]   op_a,
    input  logic [bct_pkg::WORD_W-1:0]   op_b,
    output logic [bct_pkg::WORD_W-1:0]   product
);

    logic [2*bct_pkg::WORD_W-1:0] full_prod;
    logic [bct_pkg::WORD_W-1:0]   prod_reg;

    // Hashing needs only the low half, modulo 2^32.
    assign full_prod = op_a * op_b;

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod[bct_pkg::WORD_W-1:0];
    end

    assign product = prod_reg;

endmodule

### src/bloom_change_tracker_top.sv
// Top level of the Bloom change tracker: sequencer, hash state and filters.
`timescale 1ns / 1ps

// Bloom change tracker. Requests arrive on the command channel (cmd_valid,
// cmd_stall) one key byte at a time with a command code; results leave on
// the result channel (res_valid, res_stall) from an output register.
// Every hash step goes through one shared 32x32 multiplier, so a request
// keeps cmd_stall high while the sequencer walks through its steps:
//   - a key byte that does not complete a 4-byte word: no stall;
//   - a byte that completes a word: scramble, then accumulate per hash;
//   - the final byte: scramble, finalize per hash and emit, with an
//     accumulate per hash in between when it also completes a word;
//   - clear, remark and the final byte of an overly long key: emit only.
// A result is registered in the emit step and shows on res_valid in
// the next cycle. A new request is taken while a result waits; if the
// output register is still full when the next result is ready, the
// sequencer holds in its emit step until the receiver drops res_stall.
// Reset clears both filters, the owner id and the partial key state,
// and seeds hash i with the value i.
module bloom_change_tracker_top #(
    parameter int MAX_KEY_BYTES  = 255,
    parameter int HASH_FUNCTIONS = 3
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write port for owner_id.
    input  logic                               cfg_we,
    input  logic [bct_pkg::OWNER_W-1:0]        cfg_wdata,
    // Command channel.
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [2:0]                         command,
    input  logic [7:0]                         key_byte,
    input  logic                               key_last,
    // Result channel.
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               answer,
    output logic [bct_pkg::FILTER_BITS-1:0]    tick_bits,
    output logic [bct_pkg::FILTER_BITS-1:0]    global_bits,
    output logic                               overflow
);

    localparam int CNT_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int HIDX_W = (HASH_FUNCTIONS > 1) ? $clog2(HASH_FUNCTIONS) : 1;
    localparam int WW     = bct_pkg::WORD_W;
    localparam int FB     = bct_pkg::FILTER_BITS;

    bct_pkg::state_t state_reg, state_next;

    logic [bct_pkg::OWNER_W-1:0] owner_reg;
    logic [FB-1:0]               tick_reg, tick_next;
    logic [FB-1:0]               global_reg, global_next;
    logic [WW-1:0]               acc_reg  [HASH_FUNCTIONS];
    logic [WW-1:0]               acc_next [HASH_FUNCTIONS];
    logic [WW-1:0]               partial_reg, partial_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        ovf_reg, ovf_next;
    logic                        last_reg, last_next;
    logic [2:0]                  cmd_reg, cmd_next;
    logic [HIDX_W-1:0]           hidx_reg, hidx_next;
    logic [WW-1:0]               k_reg, k_next;
    logic [FB-1:0]               bits_reg, bits_next;

    logic                        res_valid_reg, res_valid_next;
    logic                        answer_reg, answer_next;
    logic [FB-1:0]               tick_out_reg, tick_out_next;
    logic [FB-1:0]               global_out_reg, global_out_next;
    logic                        overflow_reg, overflow_next;

    logic [WW-1:0]               mul_a, mul_b, mul_p;

    logic                        accept;
    logic                        key_cmd;
    logic                        absorb;
    logic [CNT_W-1:0]            count_inc;
    logic                        word_done;
    logic                        ovf_now;
    logic                        out_free;
    logic                        hash_done;
    logic [WW-1:0]               acc_sel;
    logic [WW-1:0]               k_tail;
    logic [WW-1:0]               fin_h0;
    logic [WW-1:0]               fin_h1;
    logic [WW-1:0]               fin_h3;

    function automatic logic [WW-1:0] rotl15(input logic [WW-1:0] x);
        return {x[WW-16:0], x[WW-1:WW-15]};
    endfunction

    function automatic logic [WW-1:0] rotl13(input logic [WW-1:0] x);
        return {x[WW-14:0], x[WW-1:WW-13]};
    endfunction

    // Shared multiplier.
    bct_mul u_mul (
        .clk     (clk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    // Handshake and decode of the incoming request.
    assign cmd_stall = (state_reg != bct_pkg::ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign key_cmd   = (command == bct_pkg::CMD_MARK_CHANGED) ||
                       (command == bct_pkg::CMD_MARK_GLOBAL) ||
                       (command == bct_pkg::CMD_QUERY);
    assign absorb    = key_cmd && (count_reg < CNT_W'(MAX_KEY_BYTES));
    assign count_inc = count_reg + CNT_W'(1);
    assign word_done = absorb && (count_inc[1:0] == 2'b00);
    assign ovf_now   = ovf_reg || (key_cmd && !absorb);
    assign out_free  = !res_valid_reg || !res_stall;
    assign hash_done = (hidx_reg == HIDX_W'(HASH_FUNCTIONS - 1));

    // Finalization mix terms for the hash being worked on.
    assign acc_sel = acc_reg[hidx_reg];
    assign k_tail  = (count_reg[1:0] != 2'b00) ? k_reg : '0;
    assign fin_h0  = acc_sel ^ k_tail ^ {{(WW-CNT_W){1'b0}}, count_reg};
    assign fin_h1  = fin_h0 ^ (fin_h0 >> 16);
    assign fin_h3  = mul_p ^ (mul_p >> 16);

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bct_pkg::ST_IDLE:
            begin
                if (accept) begin
                    if ((command == bct_pkg::CMD_CLEAR) ||
                        (command == bct_pkg::CMD_REMARK)) begin
                        state_next = bct_pkg::ST_EMIT;
                    end else if (key_cmd) begin
                        if (word_done) begin
                            state_next = bct_pkg::ST_SCR_A;
                        end else if (key_last) begin
                            state_next = ovf_now ? bct_pkg::ST_EMIT : bct_pkg::ST_SCR_A;
                        end
                    end
                end
            end
            bct_pkg::ST_SCR_A: state_next = bct_pkg::ST_SCR_B;
            bct_pkg::ST_SCR_B: state_next = bct_pkg::ST_SCR_C;
            bct_pkg::ST_SCR_C:
            begin
                state_next = (count_reg[1:0] == 2'b00) ? bct_pkg::ST_ACC_A
                                                       : bct_pkg::ST_FIN_A;
            end
            bct_pkg::ST_ACC_A: state_next = bct_pkg::ST_ACC_B;
            bct_pkg::ST_ACC_B:
            begin
                if (!hash_done) begin
                    state_next = bct_pkg::ST_ACC_A;
                end else begin
                    state_next = last_reg ? bct_pkg::ST_FIN_A : bct_pkg::ST_IDLE;
                end
            end
            bct_pkg::ST_FIN_A: state_next = bct_pkg::ST_FIN_B;
            bct_pkg::ST_FIN_B: state_next = bct_pkg::ST_FIN_C;
            bct_pkg::ST_FIN_C:
            begin
                state_next = hash_done ? bct_pkg::ST_EMIT : bct_pkg::ST_FIN_A;
            end
            bct_pkg::ST_EMIT:
            begin
                if (out_free) begin
                    state_next = bct_pkg::ST_IDLE;
                end
            end
            default: state_next = bct_pkg::ST_IDLE;
        endcase
    end

    // Multiplier operand selection per sequencer step.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            bct_pkg::ST_SCR_A:
            begin
                mul_a = partial_reg;
                mul_b = bct_pkg::MM_C1;
            end
            bct_pkg::ST_SCR_B:
            begin
                mul_a = rotl15(mul_p);
                mul_b = bct_pkg::MM_C2;
            end
            bct_pkg::ST_ACC_A:
            begin
                mul_a = rotl13(acc_sel ^ k_reg);
                mul_b = bct_pkg::MM_BODY;
            end
            bct_pkg::ST_FIN_A:
            begin
                mul_a = fin_h1;
                mul_b = bct_pkg::MM_FMIX1;
            end
            bct_pkg::ST_FIN_B:
            begin
                mul_a = mul_p ^ (mul_p >> 13);
                mul_b = bct_pkg::MM_FMIX2;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Datapath updates: key absorption, hash state, filters and result.
    always_comb
    begin
        tick_next       = tick_reg;
        global_next     = global_reg;
        partial_next    = partial_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        last_next       = last_reg;
        cmd_next        = cmd_reg;
        hidx_next       = hidx_reg;
        k_next          = k_reg;
        bits_next       = bits_reg;
        answer_next     = answer_reg;
        tick_out_next   = tick_out_reg;
        global_out_next = global_out_reg;
        overflow_next   = overflow_reg;
        res_valid_next  = res_valid_reg && res_stall;
        for (int i = 0; i < HASH_FUNCTIONS; i++) begin
            acc_next[i] = acc_reg[i];
        end

        case (state_reg)
            bct_pkg::ST_IDLE:
            begin
                if (accept) begin
                    cmd_next  = command;
                    last_next = key_last;
                    hidx_next = '0;
                    bits_next = '0;
                    if (absorb) begin
                        partial_next = partial_reg |
                                       ({{(WW-8){1'b0}}, key_byte} << {count_reg[1:0], 3'b000});
                        count_next   = count_inc;
                    end else if (key_cmd) begin
                        ovf_next = 1'b1;
                    end
                end
            end
            bct_pkg::ST_SCR_C:
            begin
                k_next = mul_p;
                // A full word is consumed; a tail word stays until the key ends.
                if (count_reg[1:0] == 2'b00) begin
                    partial_next = '0;
                end
            end
            bct_pkg::ST_ACC_B:
            begin
                acc_next[hidx_reg] = mul_p + bct_pkg::MM_ADD;
                hidx_next          = hash_done ? '0 : hidx_reg + HIDX_W'(1);
            end
            bct_pkg::ST_FIN_C:
            begin
                bits_next = bits_reg | (FB'(1) << fin_h3[bct_pkg::FILTER_IDX_W-1:0]);
                hidx_next = hash_done ? '0 : hidx_reg + HIDX_W'(1);
            end
            bct_pkg::ST_EMIT:
            begin
                if (out_free) begin
                    overflow_next = 1'b0;
                    if (cmd_reg == bct_pkg::CMD_CLEAR) begin
                        answer_next = (tick_reg != '0);
                        tick_next   = '0;
                    end else if (cmd_reg == bct_pkg::CMD_REMARK) begin
                        answer_next = (global_reg != '0);
                        if (global_reg != '0) begin
                            tick_next = global_reg;
                        end
                    end else begin
                        if (ovf_reg) begin
                            answer_next   = 1'b0;
                            overflow_next = 1'b1;
                        end else if (cmd_reg == bct_pkg::CMD_MARK_CHANGED) begin
                            answer_next = (owner_reg != '0);
                            if (owner_reg != '0) begin
                                tick_next   = tick_reg | bits_reg;
                                global_next = global_reg | bits_reg;
                            end
                        end else if (cmd_reg == bct_pkg::CMD_MARK_GLOBAL) begin
                            answer_next = 1'b1;
                            global_next = global_reg | bits_reg;
                        end else begin
                            answer_next = ((tick_reg & bits_reg) == bits_reg);
                        end
                        // Key state restarts after every finished key.
                        partial_next = '0;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        for (int i = 0; i < HASH_FUNCTIONS; i++) begin
                            acc_next[i] = WW'(i);
                        end
                    end
                    tick_out_next   = tick_next;
                    global_out_next = global_next;
                    res_valid_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= bct_pkg::ST_IDLE;
            owner_reg     <= '0;
            tick_reg      <= '0;
            global_reg    <= '0;
            partial_reg   <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            hidx_reg      <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < HASH_FUNCTIONS; i++) begin
                acc_reg[i] <= WW'(i);
            end
        end else begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            global_reg    <= global_next;
            partial_reg   <= partial_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            hidx_reg      <= hidx_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < HASH_FUNCTIONS; i++) begin
                acc_reg[i] <= acc_next[i];
            end
            if (cfg_we) begin
                owner_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        last_reg       <= last_next;
        cmd_reg        <= cmd_next;
        k_reg          <= k_next;
        bits_reg       <= bits_next;
        answer_reg     <= answer_next;
        tick_out_reg   <= tick_out_next;
        global_out_reg <= global_out_next;
        overflow_reg   <= overflow_next;
    end

    assign res_valid   = res_valid_reg;
    assign answer      = answer_reg;
    assign tick_bits   = tick_out_reg;
    assign global_bits = global_out_reg;
    assign overflow    = overflow_reg;

endmodule

### bench/tb_bloom_change_tracker_top.sv
// Self-checking testbench for the Bloom change tracker with a built-in filter predictor.
`timescale 1ns / 1ps

module tb_bloom_change_tracker_top;

    localparam int MAX_KEY       = 255;
    localparam int NUM_HASHES    = 3;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;

    // Command codes that the block must drop without effect.
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       last;
    } key_req_t;

    typedef struct packed {
        logic                            answer;
        logic [bct_pkg::FILTER_BITS-1:0] tick;
        logic [bct_pkg::FILTER_BITS-1:0] glob;
        logic                            ovf;
    } filter_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [bct_pkg::OWNER_W-1:0]     cfg_wdata = '0;
    logic                            cmd_valid = 1'b0;
    logic                            cmd_stall;
    logic [2:0]                      command = bct_pkg::CMD_CLEAR;
    logic [7:0]                      key_byte = '0;
    logic                            key_last = 1'b0;
    logic                            res_valid;
    logic                            res_stall = 1'b0;
    logic                            answer;
    logic [bct_pkg::FILTER_BITS-1:0] tick_bits;
    logic [bct_pkg::FILTER_BITS-1:0] global_bits;
    logic                            overflow;

    key_req_t       key_requests[$];
    filter_result_t expected_filters[$];

    // Predictor state mirrors the block: filters, owner and the partial key hash.
    logic [bct_pkg::OWNER_W-1:0]     owner_state;
    logic [bct_pkg::FILTER_BITS-1:0] tick_state;
    logic [bct_pkg::FILTER_BITS-1:0] global_state;
    logic [31:0]                     hash_state [NUM_HASHES];
    logic [31:0]                     partial_state;
    logic [31:0]                     key_len;
    logic                            key_overflow;

    int   mismatch_count = 0;
    int   idle_cycles = 0;
    int   send_gap = 0;
    int   rx_gap = 0;
    logic calm = 1'b0;
    logic hold_arm = 1'b0;
    logic rx_hold = 1'b0;

    bloom_change_tracker_top #(
        .MAX_KEY_BYTES (MAX_KEY),
        .HASH_FUNCTIONS(NUM_HASHES)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .command    (command),
        .key_byte   (key_byte),
        .key_last   (key_last),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .answer     (answer),
        .tick_bits  (tick_bits),
        .global_bits(global_bits),
        .overflow   (overflow)
    );

    // Free-running clock.
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Prints one line per mismatch and keeps the count.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        k = k * bct_pkg::MM_C1;
        k = rotl32(k, 15);
        return k * bct_pkg::MM_C2;
    endfunction

    // Tail, length and avalanche steps of MurmurHash3 on one accumulator.
    function automatic logic [31:0] finish_hash(input logic [31:0] h);
        if (key_len[1:0] != 2'd0)
            h ^= scramble_word(partial_state);
        h ^= key_len;
        h ^= h >> 16;
        h = h * bct_pkg::MM_FMIX1;
        h ^= h >> 13;
        h = h * bct_pkg::MM_FMIX2;
        h ^= h >> 16;
        return h;
    endfunction

    function automatic void restart_key();
        int i;
        for (i = 0; i < NUM_HASHES; i++)
            hash_state[i] = 32'(i);
        partial_state = '0;
        key_len = '0;
        key_overflow = 1'b0;
    endfunction

    // Applies one accepted request and queues the filter state it should report.
    function automatic void track_request(input key_req_t rq);
        filter_result_t                  res;
        logic [31:0]                     k;
        logic [31:0]                     h;
        logic [bct_pkg::FILTER_BITS-1:0] pick;
        int                              i;
        if (rq.op > bct_pkg::CMD_REMARK)
            return;
        res = '0;
        if (rq.op == bct_pkg::CMD_CLEAR) begin
            res.answer = (tick_state != '0);
            tick_state = '0;
        end else if (rq.op == bct_pkg::CMD_REMARK) begin
            res.answer = (global_state != '0);
            if (res.answer)
                tick_state = global_state;
        end else begin
            // Absorb the byte; whole words are mixed into every accumulator.
            if (key_len >= MAX_KEY) begin
                key_overflow = 1'b1;
            end else begin
                partial_state |= {24'd0, rq.data} << (8 * key_len[1:0]);
                key_len++;
                if (key_len[1:0] == 2'd0) begin
                    k = scramble_word(partial_state);
                    for (i = 0; i < NUM_HASHES; i++) begin
                        h = rotl32(hash_state[i] ^ k, 13);
                        hash_state[i] = h * bct_pkg::MM_BODY + bct_pkg::MM_ADD;
                    end
                    partial_state = '0;
                end
            end
            if (!rq.last)
                return;
            if (key_overflow) begin
                restart_key();
                res.ovf = 1'b1;
            end else begin
                pick = '0;
                for (i = 0; i < NUM_HASHES; i++) begin
                    h = finish_hash(hash_state[i]);
                    pick[h[bct_pkg::FILTER_IDX_W-1:0]] = 1'b1;
                end
                restart_key();
                case (rq.op)
                    bct_pkg::CMD_MARK_CHANGED:
                    begin
                        if (owner_state != '0) begin
                            tick_state |= pick;
                            global_state |= pick;
                            res.answer = 1'b1;
                        end
                    end
                    bct_pkg::CMD_MARK_GLOBAL:
                    begin
                        global_state |= pick;
                        res.answer = 1'b1;
                    end
                    default:
                    begin
                        res.answer = ((tick_state & pick) == pick);
                    end
                endcase
            end
        end
        res.tick = tick_state;
        res.glob = global_state;
        expected_filters.push_back(res);
    endfunction

    function automatic key_req_t make_req(input logic [2:0] op, input logic [7:0] data,
                                          input logic last);
        key_req_t rq;
        rq.op = op;
        rq.data = data;
        rq.last = last;
        return rq;
    endfunction

    function automatic void queue_reserved();
        key_requests.push_back(make_req(3'($urandom_range(CMD_RESERVED_FIRST,
                                                          CMD_RESERVED_LAST)),
                                        8'($urandom_range(0, 255)),
                                        1'($urandom_range(0, 1))));
    endfunction

    // Queues one key; fill < 0 gives random bytes. With noise, clears, remarks,
    // reserved codes and other key commands are mixed in before the final byte.
    function automatic void queue_key(input logic [2:0] op, input int len, input int fill,
                                      input bit noise);
        int         i;
        logic [7:0] b;
        logic [2:0] c;
        for (i = 0; i < len; i++) begin
            if (noise && i > 0 && $urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0: key_requests.push_back(make_req(bct_pkg::CMD_CLEAR,
                                                       8'($urandom_range(0, 255)), 1'b0));
                    1: key_requests.push_back(make_req(bct_pkg::CMD_REMARK,
                                                       8'($urandom_range(0, 255)), 1'b1));
                    default: queue_reserved();
                endcase
            end
            b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
            c = op;
            if (noise && i + 1 < len && $urandom_range(0, 5) == 0)
                c = 3'($urandom_range(bct_pkg::CMD_MARK_CHANGED, bct_pkg::CMD_QUERY));
            key_requests.push_back(make_req(c, b, i == len - 1));
        end
    endfunction

    // Random mix of keys, clears, remarks and reserved codes.
    task automatic queue_traffic(input int item_target);
        int         count;
        int         sel;
        int         len;
        logic [2:0] op;
        count = 0;
        while (count < item_target) begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                op = bct_pkg::CMD_MARK_CHANGED;
            else if (sel < 55)
                op = bct_pkg::CMD_MARK_GLOBAL;
            else if (sel < 80)
                op = bct_pkg::CMD_QUERY;
            else if (sel < 88)
                op = bct_pkg::CMD_CLEAR;
            else if (sel < 95)
                op = bct_pkg::CMD_REMARK;
            else
                op = CMD_RESERVED_FIRST;
            if (op <= bct_pkg::CMD_QUERY) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                queue_key(op, len, -1, 1'b1);
                count += len;
            end else if (op <= bct_pkg::CMD_REMARK) begin
                key_requests.push_back(make_req(op, 8'($urandom_range(0, 255)),
                                                1'($urandom_range(0, 1))));
                count++;
            end else begin
                queue_reserved();
            end
        end
    endtask

    // Blocks until every request is taken and answered, then lets the block settle.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (key_requests.size() != 0 || cmd_valid || expected_filters.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_owner(input logic [bct_pkg::OWNER_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        owner_state = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Request driver: takes the next request once the current one is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        key_req_t nxt;
        if (!rst_n) begin
            cmd_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (cmd_valid && !cmd_stall)
                track_request(make_req(command, key_byte, key_last));
            if (!cmd_valid || !cmd_stall) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    cmd_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    send_gap <= $urandom_range(0, 4);
                    cmd_valid <= 1'b0;
                end else if (key_requests.size() != 0) begin
                    nxt = key_requests.pop_front();
                    command <= nxt.op;
                    key_byte <= nxt.data;
                    key_last <= nxt.last;
                    cmd_valid <= 1'b1;
                end else begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each accepted result and drives random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        filter_result_t want;
        logic           stall_now;
        if (!rst_n) begin
            res_stall <= 1'b0;
            rx_gap <= 0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_filters.size() == 0) begin
                    report_mismatch("result with no request waiting for it");
                end else begin
                    want = expected_filters.pop_front();
                    if (answer !== want.answer)
                        report_mismatch($sformatf("answer got %b want %b",
                                                  answer, want.answer));
                    if (tick_bits !== want.tick)
                        report_mismatch($sformatf("tick_bits got %h want %h",
                                                  tick_bits, want.tick));
                    if (global_bits !== want.glob)
                        report_mismatch($sformatf("global_bits got %h want %h",
                                                  global_bits, want.glob));
                    if (overflow !== want.ovf)
                        report_mismatch($sformatf("overflow got %b want %b",
                                                  overflow, want.ovf));
                end
            end
            stall_now = 1'b0;
            if (rx_gap != 0) begin
                rx_gap <= rx_gap - 1;
                stall_now = 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(0, 4);
                stall_now = 1'b1;
            end
            res_stall <= stall_now || rx_hold;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    initial
    begin
        wait (hold_arm);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog on cycles in which neither channel moves.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles", idle_cycles);
                $display("Regression FAIL");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Stimulus: reset, directed requests, then random phases under several owners.
    initial
    begin
        int phase;
        owner_state = '0;
        tick_state = '0;
        global_state = '0;
        restart_key();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Owner still zero: mark-changed is refused, a global mark still lands, empty filters report zero.
        queue_key(bct_pkg::CMD_MARK_CHANGED, 1, 8'h00, 1'b0);
        queue_key(bct_pkg::CMD_QUERY, 1, 8'hff, 1'b0);
        key_requests.push_back(make_req(bct_pkg::CMD_CLEAR, 8'h00, 1'b0));
        key_requests.push_back(make_req(bct_pkg::CMD_REMARK, 8'hff, 1'b1));
        key_requests.push_back(make_req(CMD_RESERVED_FIRST, 8'ha5, 1'b1));
        key_requests.push_back(make_req(CMD_RESERVED_LAST, 8'h5a, 1'b0));
        queue_reserved();
        queue_key(bct_pkg::CMD_MARK_GLOBAL, 4, 8'hff, 1'b0);
        wait_idle();
        write_owner(16'hffff);

        // Remark copies global, queries hit, clear mid-key keeps the partial key.
        key_requests.push_back(make_req(bct_pkg::CMD_REMARK, 8'h00, 1'b0));
        queue_key(bct_pkg::CMD_QUERY, 4, 8'hff, 1'b0);
        key_requests.push_back(make_req(bct_pkg::CMD_CLEAR, 8'hff, 1'b1));
        queue_key(bct_pkg::CMD_MARK_CHANGED, 5, 8'h00, 1'b0);
        key_requests.push_back(make_req(bct_pkg::CMD_MARK_CHANGED, 8'h12, 1'b0));
        key_requests.push_back(make_req(bct_pkg::CMD_CLEAR, 8'h00, 1'b1));
        key_requests.push_back(make_req(bct_pkg::CMD_REMARK, 8'h00, 1'b0));
        key_requests.push_back(make_req(bct_pkg::CMD_QUERY, 8'h34, 1'b1));

        // Random phases, each after a fresh owner id write.
        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: write_owner(16'($urandom_range(2, 16'hfffe)));
                1: write_owner(16'h0000);
                2: write_owner(16'h0001);
                3: write_owner(16'($urandom_range(1, 16'hffff)));
                default: write_owner(16'hffff);
            endcase
            if (phase == 1)
                queue_key(3'($urandom_range(bct_pkg::CMD_MARK_CHANGED, bct_pkg::CMD_QUERY)),
                          MAX_KEY, -1, 1'b0);
            if (phase == 2) begin
                hold_arm = 1'b1;
                repeat (8) begin
                    queue_key(bct_pkg::CMD_MARK_CHANGED, 1, -1, 1'b0);
                    key_requests.push_back(make_req(bct_pkg::CMD_REMARK, 8'h00, 1'b1));
                end
            end
            if (phase == 3)
                queue_key(3'($urandom_range(bct_pkg::CMD_MARK_CHANGED, bct_pkg::CMD_QUERY)),
                          $urandom_range(MAX_KEY + 1, MAX_KEY + 7), -1, 1'b1);
            if (phase == 4)
                calm = 1'b1;
            queue_traffic(18);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### bloom_change_tracker_top.f
src/bct_pkg.sv
src/bct_mul.sv
src/bloom_change_tracker_top.sv
bench/tb_bloom_change_tracker_top.sv
